### hw/rtl/afu_pkg.sv
// ----------------------------------------------------------------------------
// Activation function unit package
// Shared widths, the mode codes, saturation and the sigmoid and tanh tables.
// ----------------------------------------------------------------------------
package afu_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int FRAC_BITS  = 12;
  localparam int ELEM_W     = 16;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int MAG_W      = ELEM_W + 1;
  localparam int WIDE_W     = 2 * ELEM_W + 2;
  localparam int ONE        = 1 << FRAC_BITS;

  // Working format for the table build: unsigned Q.30.
  localparam int          WORK_BITS    = 30;
  localparam logic [63:0] WORK_ONE     = 64'd1 << WORK_BITS;
  localparam int          SERIES_TERMS = 20;

  typedef logic [TABLE_SIZE-1:0][ELEM_W-1:0] afu_tab_t;

  typedef enum logic [2:0] {
    MODE_SIGMOID  = 3'd0,
    MODE_SIG_DER  = 3'd1,
    MODE_RELU     = 3'd2,
    MODE_RELU_DER = 3'd3,
    MODE_TANH     = 3'd4,
    MODE_TANH_DER = 3'd5,
    MODE_PASS     = 3'd6
  } afu_mode_e;

  localparam logic [2:0] MODE_RESET = MODE_PASS;

  // One element word together with its last flag.
  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic                     last;
  } afu_elem_t;

  function automatic logic signed [ELEM_W-1:0] sat_elem(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'((1 << (ELEM_W - 1)) - 1);
    lo = -WIDE_W'(1 << (ELEM_W - 1));
    if (v > hi) begin
      return hi[ELEM_W-1:0];
    end else if (v < lo) begin
      return lo[ELEM_W-1:0];
    end
    return v[ELEM_W-1:0];
  endfunction

  // Restoring long division; only the table build at elaboration calls it.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] wmul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (WORK_ONE >> 1)) >> WORK_BITS;
  endfunction

  // e^-f for f in [0, 1], alternating Taylor series.
  function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = WORK_ONE;
    term = WORK_ONE;
    for (int i = 1; i <= SERIES_TERMS; i++) begin
      term = div_u64(wmul(term, f), 64'(i));
      if ((i % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // e^-u for u below 64: fraction by series, whole part by repeated e^-1.
  function automatic logic [63:0] exp_neg(input logic [63:0] u);
    logic [63:0] e1;
    logic [63:0] r;
    logic [63:0] n;
    e1 = exp_neg_frac(WORK_ONE);
    r  = exp_neg_frac(u & (WORK_ONE - 64'd1));
    n  = u >> WORK_BITS;
    for (int i = 0; i < 64; i++) begin
      if (64'(i) < n) begin
        r = wmul(r, e1);
      end
    end
    if (r > WORK_ONE) begin
      r = WORK_ONE;
    end
    return r;
  endfunction

  // Entry k holds f((k + 0.5) * 8 / TABLE_SIZE), evaluated at elaboration.
  function automatic afu_tab_t build_tab(input logic want_tanh);
    afu_tab_t    tab;
    logic [63:0] t;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] q;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      t = ((64'(2 * k + 1) * 64'd4) << WORK_BITS) / 64'(TABLE_SIZE);
      if (want_tanh) begin
        e = exp_neg(t << 1);
        d = WORK_ONE + e;
        q = div_u64(((WORK_ONE - e) << FRAC_BITS) + (d >> 1), d);
      end else begin
        e = exp_neg(t);
        d = WORK_ONE + e;
        q = div_u64((WORK_ONE << FRAC_BITS) + (d >> 1), d);
      end
      tab[k] = q[ELEM_W-1:0];
    end
    return tab;
  endfunction

  localparam afu_tab_t SIG_TAB  = build_tab(1'b0);
  localparam afu_tab_t TANH_TAB = build_tab(1'b1);

endpackage

### hw/rtl/afu_lut.sv
// ----------------------------------------------------------------------------
// Activation table lookup
// Indexes the sigmoid and tanh tables by the saturated magnitude of x.
// ----------------------------------------------------------------------------
module afu_lut (
  input  logic signed [afu_pkg::ELEM_W-1:0] x_i,
  output logic        [afu_pkg::ELEM_W-1:0] sig_o,
  output logic        [afu_pkg::ELEM_W-1:0] tanh_o
);

  localparam int ProdW = afu_pkg::MAG_W + afu_pkg::IDX_W + 1;
  localparam int Shift = afu_pkg::FRAC_BITS + 3;

  logic signed [afu_pkg::MAG_W-1:0] x_ext;
  logic        [afu_pkg::MAG_W-1:0] mag;
  logic        [ProdW-1:0]          scaled;
  logic        [ProdW-1:0]          shifted;
  logic        [afu_pkg::IDX_W-1:0] idx;

  always_comb begin
    x_ext   = afu_pkg::MAG_W'(x_i);
    mag     = x_i[afu_pkg::ELEM_W-1] ? unsigned'(-x_ext) : unsigned'(x_ext);
    scaled  = ProdW'(mag) * ProdW'(afu_pkg::TABLE_SIZE);
    shifted = scaled >> Shift;
    // Large magnitudes all land on the last entry.
    if (shifted > ProdW'(afu_pkg::TABLE_SIZE - 1)) begin
      idx = afu_pkg::IDX_W'(afu_pkg::TABLE_SIZE - 1);
    end else begin
      idx = shifted[afu_pkg::IDX_W-1:0];
    end
  end

  assign sig_o  = afu_pkg::SIG_TAB[idx];
  assign tanh_o = afu_pkg::TANH_TAB[idx];

endmodule

### hw/rtl/afu_core.sv
// ----------------------------------------------------------------------------
// Activation datapath
// Selects and saturates the result of the configured activation for one word.
// ----------------------------------------------------------------------------
module afu_core (
  input  logic [2:0]                        mode_i,
  input  logic signed [afu_pkg::ELEM_W-1:0] x_i,
  output logic signed [afu_pkg::ELEM_W-1:0] y_o
);

  localparam int W = afu_pkg::WIDE_W;

  logic        [afu_pkg::ELEM_W-1:0] sig_entry;
  logic        [afu_pkg::ELEM_W-1:0] tanh_entry;
  logic signed [W-1:0]               x_w;
  logic signed [W-1:0]               one_w;
  logic signed [W-1:0]               sig_w;
  logic signed [W-1:0]               tanh_w;
  logic signed [W-1:0]               der_prod;
  logic signed [W-1:0]               sq_prod;
  logic signed [W-1:0]               y_w;

  afu_lut u_lut (
    .x_i    (x_i),
    .sig_o  (sig_entry),
    .tanh_o (tanh_entry)
  );

  always_comb begin
    x_w    = W'(x_i);
    one_w  = W'(afu_pkg::ONE);
    sig_w  = signed'(W'(sig_entry));
    tanh_w = signed'(W'(tanh_entry));
    // Arithmetic shifts floor toward minus infinity, as the format requires.
    der_prod = (x_w * (one_w - x_w)) >>> afu_pkg::FRAC_BITS;
    sq_prod  = (x_w * x_w) >>> afu_pkg::FRAC_BITS;
    unique case (afu_pkg::afu_mode_e'(mode_i))
      afu_pkg::MODE_SIGMOID:  y_w = x_i[afu_pkg::ELEM_W-1] ? one_w - sig_w : sig_w;
      afu_pkg::MODE_SIG_DER:  y_w = der_prod;
      afu_pkg::MODE_RELU:     y_w = (x_w > 0) ? x_w : '0;
      afu_pkg::MODE_RELU_DER: y_w = x_i[afu_pkg::ELEM_W-1] ? '0 : one_w;
      afu_pkg::MODE_TANH:     y_w = x_i[afu_pkg::ELEM_W-1] ? -tanh_w : tanh_w;
      afu_pkg::MODE_TANH_DER: y_w = one_w - sq_prod;
      afu_pkg::MODE_PASS:     y_w = x_w;
      default:                y_w = x_w;
    endcase
  end

  assign y_o = afu_pkg::sat_elem(y_w);

endmodule

### hw/rtl/activation_function_unit.sv
// ----------------------------------------------------------------------------
// Activation function unit
// Applies the configured activation to a stream of signed fixed-point words.
// ----------------------------------------------------------------------------
// Usage:
//   A word (element_value_i, last_element_i) is taken at a clock edge where
//   start_i is high and busy_o is low. busy_o is always low, so one word can
//   be taken in every cycle.
//   The result appears on activated_value_o and last_out_o for exactly one
//   cycle, marked by done_o, once the word has passed in_q and out_q. The
//   receiver cannot stall; results must be captured when done_o is high.
//   Throughput is one word per cycle. The path from the input register to
//   the result register holds the table lookup, a 16 by 17 bit and a 16 by
//   16 bit multiply in parallel, and the saturation.
//   cfg_we_i writes cfg_data_i into the mode register: 0 sigmoid, 1 sigmoid
//   derivative, 2 relu, 3 relu derivative, 4 tanh, 5 tanh derivative,
//   6 pass; code 7 also passes the word through. Write it only while no
//   word is in flight.
//   Reset clears the pipeline valid bits and sets the mode to pass. The
//   tables are constants, so no warm-up is needed after reset.
// ----------------------------------------------------------------------------
module activation_function_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [afu_pkg::ELEM_W-1:0] element_value_i,
  input  logic                              last_element_i,
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_data_i,
  output logic                              done_o,
  output logic signed [afu_pkg::ELEM_W-1:0] activated_value_o,
  output logic                              last_out_o
);

  logic [2:0]                        mode_q;
  logic                              in_vld_q;
  afu_pkg::afu_elem_t                in_q;
  logic                              out_vld_q;
  afu_pkg::afu_elem_t                out_q;
  afu_pkg::afu_elem_t                out_d;
  logic signed [afu_pkg::ELEM_W-1:0] y;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= afu_pkg::MODE_RESET;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i && !busy_o;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q.value <= element_value_i;
      in_q.last  <= last_element_i;
    end
    if (in_vld_q) begin
      out_q <= out_d;
    end
  end

  afu_core u_core (
    .mode_i (mode_q),
    .x_i    (in_q.value),
    .y_o    (y)
  );

  always_comb begin
    out_d.value = y;
    out_d.last  = in_q.last;
  end

  assign done_o            = out_vld_q;
  assign activated_value_o = out_q.value;
  assign last_out_o        = out_q.last;

  // Every result comes from a taken word that has passed through in_q and out_q.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 2))
    else $error("result without a word taken two cycles before");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("accepted word produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (last_out_o == $past(last_element_i, 2)))
    else $error("last flag not carried with its word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(mode_q, 1) == afu_pkg::MODE_PASS && $past(cfg_we_i, 1) == 1'b0 &&
     $past(cfg_we_i, 2) == 1'b0)
      |-> (activated_value_o == $past(element_value_i, 2)))
    else $error("pass mode changed the word");

endmodule
